// File: rtl/core/color_difference_mask_dilate_core_macros.svh
// ----------------------------------------------------------------------------
// color difference mask dilate core assertion macros
// concurrent assertion helpers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef COLOR_DIFFERENCE_MASK_DILATE_CORE_MACROS_SVH
`define COLOR_DIFFERENCE_MASK_DILATE_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define CDMD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be true outside reset
`define CDMD_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define CDMD_ASSERT(name, clk, rst_n, prop, msg)
`define CDMD_ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

// File: rtl/core/cdmd_pkg.sv
// ----------------------------------------------------------------------------
// cdmd_pkg
// shared types and constants of the color difference mask dilate core
// ----------------------------------------------------------------------------
`default_nettype none

package cdmd_pkg;

  // default line and frame limits
  localparam int DefMaxWidth  = 2048;
  localparam int DefMaxHeight = 2048;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] RegColorMode     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDiffThreshold = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFrameWidth    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegFrameHeight   = 2'd3;

  // register reset values
  localparam logic       ColorModeRst     = 1'b0;
  localparam logic [7:0] DiffThresholdRst = 8'd80;
  localparam int         FrameWidthRst    = 640;
  localparam int         FrameHeightRst   = 480;

  // color mode codes
  localparam logic ModeRedMinusBlue = 1'b0;
  localparam logic ModeBlueMinusRed = 1'b1;

  // action codes
  localparam logic ActPixel = 1'b0;
  localparam logic ActDrain = 1'b1;

  // output queue
  localparam int OutFifoDepth = 3;
  localparam int OutPtrW      = 2;
  localparam int OutCntW      = 2;

  typedef struct packed {
    logic mask_bit;
    logic frame_end;
  } cdmd_result_t;

  typedef struct packed {
    logic rd_en;
    logic wr_cur;
    logic wr_prior;
  } cdmd_lb_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/cdmd_line_buf.sv
// ----------------------------------------------------------------------------
// cdmd_line_buf
// current and prior row mask memories with write-to-read forwarding
// ----------------------------------------------------------------------------
`default_nettype none

module cdmd_line_buf #(
  parameter int Depth = cdmd_pkg::DefMaxWidth
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  cdmd_pkg::cdmd_lb_ctrl_t     ctrl_i,
  input  wire  [$clog2(Depth)-1:0]    rd_addr_i,
  input  wire  [$clog2(Depth)-1:0]    wr_addr_i,
  input  wire                         cur_wr_data_i,
  input  wire                         prior_wr_data_i,
  output logic                        cur0_o,
  output logic                        cur1_o,
  output logic                        prior0_o
);
  import cdmd_pkg::*;

  localparam int AW = $clog2(Depth);

  logic cur_mem   [Depth];
  logic prior_mem [Depth];

  logic [AW-1:0] rd_addr1;
  logic          cur0_q, cur1_q, prior0_q;
  logic          fwd_cur0_q, fwd_cur1_q, fwd_prior_q;
  logic          fwd_cur_data_q, fwd_prior_data_q;

  assign rd_addr1 = rd_addr_i + AW'(1);

  // storage, read data registered
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_cur) begin
      cur_mem[wr_addr_i] <= cur_wr_data_i;
    end
    if (ctrl_i.wr_prior) begin
      prior_mem[wr_addr_i] <= prior_wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      cur0_q           <= cur_mem[rd_addr_i];
      cur1_q           <= cur_mem[rd_addr1];
      prior0_q         <= prior_mem[rd_addr_i];
      fwd_cur_data_q   <= cur_wr_data_i;
      fwd_prior_data_q <= prior_wr_data_i;
    end
  end

  // same-cycle write hits a read address: take the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_cur0_q  <= 1'b0;
      fwd_cur1_q  <= 1'b0;
      fwd_prior_q <= 1'b0;
    end else if (ctrl_i.rd_en) begin
      fwd_cur0_q  <= ctrl_i.wr_cur && (wr_addr_i == rd_addr_i);
      fwd_cur1_q  <= ctrl_i.wr_cur && (wr_addr_i == rd_addr1);
      fwd_prior_q <= ctrl_i.wr_prior && (wr_addr_i == rd_addr_i);
    end
  end

  assign cur0_o   = fwd_cur0_q  ? fwd_cur_data_q   : cur0_q;
  assign cur1_o   = fwd_cur1_q  ? fwd_cur_data_q   : cur1_q;
  assign prior0_o = fwd_prior_q ? fwd_prior_data_q : prior0_q;

endmodule

`default_nettype wire

// File: rtl/core/cdmd_out_fifo.sv
// ----------------------------------------------------------------------------
// cdmd_out_fifo
// small result queue between the dilation stage and the output port
// ----------------------------------------------------------------------------
`default_nettype none

module cdmd_out_fifo (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   push_i,
  input  cdmd_pkg::cdmd_result_t                push_data_i,
  input  wire                                   pop_i,
  output logic                                  valid_o,
  output cdmd_pkg::cdmd_result_t                data_o,
  output logic [cdmd_pkg::OutCntW-1:0]          count_o
);
  import cdmd_pkg::*;

  cdmd_result_t         mem_q [OutFifoDepth];
  logic [OutPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [OutPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [OutCntW-1:0]   count_q, count_d;
  logic                 do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == OutPtrW'(OutFifoDepth - 1)) ? '0 : wr_ptr_q + OutPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == OutPtrW'(OutFifoDepth - 1)) ? '0 : rd_ptr_q + OutPtrW'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + OutCntW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - OutCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

`default_nettype wire

// File: rtl/core/color_difference_mask_dilate_core.sv
// ----------------------------------------------------------------------------
// color_difference_mask_dilate_core
// channel difference threshold followed by 3x3 cross dilation, raster order
// ----------------------------------------------------------------------------
// The core takes one word per clock while in_ready_o is high and sends one
// result word per clock while out_ready_i is high and a result is queued.
// Each pixel word forms a raw mask bit (red minus blue, or blue minus red,
// signed, strictly above the threshold) and the raw mask is dilated with a
// cross: center, up, down, left and right, ignoring neighbors off the frame.
// A pixel in row r gives the result for the pixel above it, so the output
// lags the input by one row and a pixel in the first row gives no word; the
// last row is pushed out by drain words, one result each, and frame_end marks
// the bottom right result. A result passes the registered line buffer read
// and the dilation stage into the result queue. The raw rows live in two
// 1-bit line buffers of MAX_WIDTH entries; per word the current row buffer
// is read at two columns and the prior row buffer at one, each is written at
// most once, and write-to-read forwarding covers overlaps, so there is no
// clearing pass after reset. A three entry result queue lets input keep
// flowing while the output side stalls; in_ready_o comes from registers only.
// Writing frame_width or frame_height restarts the frame; configuration is
// to be written only while the core is idle, which the core does not enforce.
`default_nettype none

`include "color_difference_mask_dilate_core_macros.svh"

module color_difference_mask_dilate_core #(
  parameter int MAX_WIDTH  = cdmd_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = cdmd_pkg::DefMaxHeight
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // configuration write port
  input  wire                              cfg_we_i,
  input  wire  [cdmd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire  [cdmd_pkg::CfgDataW-1:0]    cfg_data_i,
  // input words
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              action_i,
  input  wire  [7:0]                       pixel_blue_i,
  input  wire  [7:0]                       pixel_red_i,
  // result words
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic                             mask_bit_o,
  output logic                             frame_end_o
);
  import cdmd_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CmpW  = CfgDataW + 1;
  localparam int WidthRst  = (FrameWidthRst  > MAX_WIDTH)  ? MAX_WIDTH  : FrameWidthRst;
  localparam int HeightRst = (FrameHeightRst > MAX_HEIGHT) ? MAX_HEIGHT : FrameHeightRst;
  localparam logic [CW-1:0] WidthLastRst  = CW'(WidthRst - 1);
  localparam logic [RW-1:0] HeightLastRst = RW'(HeightRst - 1);

  // configuration, geometry kept as last column and last row
  logic          color_mode_q;
  logic [7:0]    diff_thr_q;
  logic [CW-1:0] w_last_q, w_last_cfg;
  logic [RW-1:0] h_last_q, h_last_cfg;
  logic          restart;

  // input and drain positions
  logic [CW-1:0] in_col_q, in_col_d;
  logic [RW-1:0] in_row_q, in_row_d;
  logic [CW-1:0] drain_col_q, drain_col_d;
  logic          tail_q, tail_d;

  // stage a: accept and issue the line buffer reads
  logic          accept, is_pix, is_drain;
  logic [CW-1:0] a_col;
  logic signed [9:0] diff;
  logic          raw_m;

  // stage b: dilation and write back
  logic          b_valid_q;
  logic          b_pix_q, b_emit_q, b_m_q, b_up_q, b_left_q, b_right_q, b_end_q;
  logic [CW-1:0] b_col_q;
  logic          left_q;      // raw mask of the column to the left, same row
  logic          dil;

  cdmd_lb_ctrl_t lb_ctrl;
  logic          cur0, cur1, prior0;

  cdmd_result_t          res_push, res_out;
  logic                  fifo_push, fifo_pop, fifo_valid;
  logic [OutCntW-1:0]    fifo_count;
  logic [OutCntW:0]      credit;

  // geometry clamp: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (cfg_data_i == '0) begin
      w_last_cfg = '0;
    end else if ({1'b0, cfg_data_i} > CmpW'(MAX_WIDTH)) begin
      w_last_cfg = CW'(MAX_WIDTH - 1);
    end else begin
      w_last_cfg = CW'(cfg_data_i - CfgDataW'(1));
    end
    if (cfg_data_i == '0) begin
      h_last_cfg = '0;
    end else if ({1'b0, cfg_data_i} > CmpW'(MAX_HEIGHT)) begin
      h_last_cfg = RW'(MAX_HEIGHT - 1);
    end else begin
      h_last_cfg = RW'(cfg_data_i - CfgDataW'(1));
    end
  end

  assign restart = cfg_we_i &&
                   ((cfg_index_i == RegFrameWidth) || (cfg_index_i == RegFrameHeight));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= ColorModeRst;
      diff_thr_q   <= DiffThresholdRst;
      w_last_q     <= WidthLastRst;
      h_last_q     <= HeightLastRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegColorMode:     color_mode_q <= cfg_data_i[0];
        RegDiffThreshold: diff_thr_q   <= cfg_data_i[7:0];
        RegFrameWidth:    w_last_q     <= w_last_cfg;
        RegFrameHeight:   h_last_q     <= h_last_cfg;
        default:          ;
      endcase
    end
  end

  // credit check: queue entries plus the word in stage b stay within the queue
  assign credit     = {1'b0, fifo_count} + {{OutCntW{1'b0}}, b_valid_q};
  assign in_ready_o = (credit <= (OutCntW + 1)'(OutFifoDepth - 1));

  assign accept   = in_valid_i && in_ready_o;
  assign is_pix   = accept && (action_i == ActPixel);
  // a drain with no last row pending does nothing at all
  assign is_drain = accept && (action_i == ActDrain) && tail_q;
  assign a_col    = is_pix ? in_col_q : drain_col_q;

  // signed channel difference and strict threshold
  always_comb begin
    if (color_mode_q == ModeBlueMinusRed) begin
      diff = $signed({2'b00, pixel_blue_i}) - $signed({2'b00, pixel_red_i});
    end else begin
      diff = $signed({2'b00, pixel_red_i}) - $signed({2'b00, pixel_blue_i});
    end
    raw_m = (diff > $signed({2'b00, diff_thr_q}));
  end

  // raster position walk; the end of the last row arms the drain phase
  always_comb begin
    in_col_d    = in_col_q;
    in_row_d    = in_row_q;
    drain_col_d = drain_col_q;
    tail_d      = tail_q;
    if (is_pix) begin
      tail_d = 1'b0;
      if (in_col_q == w_last_q) begin
        in_col_d = '0;
        if (in_row_q == h_last_q) begin
          in_row_d    = '0;
          tail_d      = 1'b1;
          drain_col_d = '0;
        end else begin
          in_row_d = in_row_q + RW'(1);
        end
      end else begin
        in_col_d = in_col_q + CW'(1);
      end
    end else if (is_drain) begin
      if (drain_col_q == w_last_q) begin
        tail_d      = 1'b0;
        drain_col_d = '0;
      end else begin
        drain_col_d = drain_col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q    <= '0;
      in_row_q    <= '0;
      drain_col_q <= '0;
      tail_q      <= 1'b0;
    end else if (restart) begin
      in_col_q    <= '0;
      in_row_q    <= '0;
      drain_col_q <= '0;
      tail_q      <= 1'b0;
    end else begin
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      drain_col_q <= drain_col_d;
      tail_q      <= tail_d;
    end
  end

  // stage b control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= is_pix || is_drain;
    end
  end

  // stage b payload; neighbor enables follow the frame edges
  always_ff @(posedge clk_i) begin
    if (is_pix || is_drain) begin
      b_pix_q   <= is_pix;
      b_col_q   <= a_col;
      b_m_q     <= raw_m;
      b_emit_q  <= is_pix ? (in_row_q != '0) : 1'b1;
      b_up_q    <= is_pix ? (in_row_q > RW'(1)) : (h_last_q != '0);
      b_left_q  <= (a_col != '0);
      b_right_q <= (a_col != w_last_q);
      b_end_q   <= is_drain && (a_col == w_last_q);
    end
    if (b_valid_q) begin
      left_q <= cur0;
    end
  end

  // line buffers: read at the accepted column, write back in the following cycle
  assign lb_ctrl.rd_en    = is_pix || is_drain;
  assign lb_ctrl.wr_cur   = b_valid_q && b_pix_q;
  assign lb_ctrl.wr_prior = b_valid_q && b_pix_q && b_emit_q;

  cdmd_line_buf #(
    .Depth (MAX_WIDTH)
  ) u_line_buf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (lb_ctrl),
    .rd_addr_i       (a_col),
    .wr_addr_i       (b_col_q),
    .cur_wr_data_i   (b_m_q),
    .prior_wr_data_i (cur0),
    .cur0_o          (cur0),
    .cur1_o          (cur1),
    .prior0_o        (prior0)
  );

  // cross dilation; for a pixel word the raw bit below is the new pixel,
  // for a drain word the bottom row has nothing below
  assign dil = cur0 | (b_pix_q & b_m_q) | (b_up_q & prior0) |
               (b_left_q & left_q) | (b_right_q & cur1);

  assign fifo_push          = b_valid_q && b_emit_q;
  assign res_push.mask_bit  = dil;
  assign res_push.frame_end = b_end_q;
  assign fifo_pop           = out_valid_o && out_ready_i;

  cdmd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i (res_push),
    .pop_i       (fifo_pop),
    .valid_o     (fifo_valid),
    .data_o      (res_out),
    .count_o     (fifo_count)
  );

  assign out_valid_o = fifo_valid;
  assign mask_bit_o  = res_out.mask_bit;
  assign frame_end_o = res_out.frame_end;

  // a dilated word always finds room in the result queue
  `CDMD_ASSERT_NEVER(a_fifo_overflow, clk_i, rst_ni,
    fifo_push && (fifo_count == OutCntW'(OutFifoDepth)) && !fifo_pop,
    "result queue overflow")

  // while the last row drains, the input side waits at the frame origin
  `CDMD_ASSERT(a_tail_origin, clk_i, rst_ni,
    tail_q |-> ((in_col_q == '0) && (in_row_q == '0)),
    "drain phase with input away from frame origin")

  // drain column stays inside the frame
  `CDMD_ASSERT(a_drain_col_range, clk_i, rst_ni,
    drain_col_q <= w_last_q,
    "drain column beyond last column")

  // stage b only ever holds a word taken in the cycle before
  `CDMD_ASSERT(a_stage_b_origin, clk_i, rst_ni,
    b_valid_q |-> $past(in_valid_i && in_ready_o),
    "stage b valid without a taken word")

endmodule

`default_nettype wire
